// ----- src/positional_ordered_list_macros.svh -----
// ----------------------------------------------------------------------------
// positional_ordered_list assertion macros
// shared concurrent check forms, sampled on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

// property that must hold at every sampled edge
`define POL_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("positional_ordered_list check failed");

// same-cycle implication
`define POL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional_ordered_list check failed");

// next-cycle implication
`define POL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional_ordered_list check failed");

`endif

// ----- src/pol_pkg.sv -----
// ----------------------------------------------------------------------------
// pol_pkg
// types, codes and constants shared by the positional ordered list
// ----------------------------------------------------------------------------
`default_nettype none

package pol_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 8;
    // position arithmetic one bit wider so that length + 1 never wraps
    localparam int POSX_W    = POS_W + 1;

    typedef enum logic [2:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_REAR  = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_REAR  = 3'd4,
        ACT_DEL_POS   = 3'd5,
        ACT_READ      = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_POS   = 2'd3
    } status_t;

    typedef struct packed {
        action_t                    action;
        logic signed [VALUE_W-1:0]  value;
        logic        [POS_W-1:0]    position;
    } req_t;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  element;
        logic        [POS_W-1:0]    slot;
        logic        [POS_W-1:0]    length;
        logic                       last;
    } rsp_t;

    typedef struct packed {
        logic exec;   // run the accepted request into the result register
        logic step;   // advance readout to the next element
    } pol_cmd_t;

    typedef struct packed {
        logic last;   // beat held in the result register is the final one
    } pol_sts_t;

endpackage

`default_nettype wire

// ----- src/pol_ctrl.sv -----
// ----------------------------------------------------------------------------
// pol_ctrl
// handshake controller: sequences request execution and readout beats
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_ordered_list_macros.svh"

module pol_ctrl
    import pol_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output pol_cmd_t      cmd,
    input  wire pol_sts_t sts
);

    typedef enum logic {
        IDLE,
        BUSY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   final_taken;

    // the result register frees up in the cycle its final beat is taken
    assign final_taken = (state_reg == BUSY) && rsp_ready && sts.last;
    assign req_ready   = (state_reg == IDLE) || final_taken;
    assign rsp_valid   = rsp_valid_reg;

    always_comb
    begin
        cmd.exec = req_valid && req_ready;
        cmd.step = (state_reg == BUSY) && rsp_ready && !sts.last;

        state_next = state_reg;
        if (cmd.exec)
        begin
            state_next = BUSY;
        end
        else if (final_taken)
        begin
            state_next = IDLE;
        end
        rsp_valid_next = (state_next == BUSY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    `POL_ASSERT_IMPL(a_step_not_final, cmd.step, !sts.last && rsp_valid)
    `POL_ASSERT_IMPL(a_exec_excl_step, cmd.exec, !cmd.step)
    `POL_ASSERT_NEXT(a_exec_gives_beat, cmd.exec, rsp_valid)

endmodule

`default_nettype wire

// ----- src/pol_dp.sv -----
// ----------------------------------------------------------------------------
// pol_dp
// datapath: shifting cell array, occupancy and the result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_ordered_list_macros.svh"

module pol_dp
    import pol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire req_t     req,
    input  wire pol_cmd_t cmd,
    output pol_sts_t      sts,
    output rsp_t          rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [POSX_W-1:0] DEPTH_X = POSX_W'(DEPTH);

    logic signed [VALUE_W-1:0] cells_reg  [DEPTH];
    logic signed [VALUE_W-1:0] cells_next [DEPTH];
    logic [OCC_W-1:0]          occ_reg;
    logic [OCC_W-1:0]          occ_next;
    logic [IDX_W-1:0]          rd_idx_reg;
    logic [IDX_W-1:0]          rd_idx_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic signed [VALUE_W-1:0] element_reg;
    logic signed [VALUE_W-1:0] element_next;
    logic [POS_W-1:0]          slot_reg;
    logic [POS_W-1:0]          slot_next;
    logic [POS_W-1:0]          length_reg;
    logic [POS_W-1:0]          length_next;
    logic                      last_reg;
    logic                      last_next;

    logic [POSX_W-1:0] occ_x;
    logic [POSX_W-1:0] pos_x;
    logic [POSX_W-1:0] ins_pos;
    logic [POSX_W-1:0] del_pos;
    logic [IDX_W-1:0]  ins_idx;
    logic [IDX_W-1:0]  del_idx;
    logic [POSX_W-1:0] rd_nxt;
    logic              full;
    logic              empty;
    logic              ins_ok;
    logic              del_ok;

    assign occ_x = POSX_W'(occ_reg);
    assign pos_x = POSX_W'(req.position);
    assign full  = (occ_x == DEPTH_X);
    assign empty = (occ_reg == '0);

    always_comb
    begin
        case (req.action)
            ACT_INS_FRONT: ins_pos = POSX_W'(1);
            ACT_INS_REAR:  ins_pos = occ_x + POSX_W'(1);
            default:       ins_pos = pos_x;
        endcase
        case (req.action)
            ACT_DEL_FRONT: del_pos = POSX_W'(1);
            ACT_DEL_REAR:  del_pos = occ_x;
            default:       del_pos = pos_x;
        endcase
    end

    assign ins_ok  = (ins_pos != '0) && (ins_pos <= occ_x + POSX_W'(1));
    assign del_ok  = (del_pos != '0) && (del_pos <= occ_x);
    assign ins_idx = IDX_W'(ins_pos - POSX_W'(1));
    assign del_idx = IDX_W'(del_pos - POSX_W'(1));
    assign rd_nxt  = POSX_W'(rd_idx_reg) + POSX_W'(1);

    always_comb
    begin
        cells_next   = cells_reg;
        occ_next     = occ_reg;
        rd_idx_next  = rd_idx_reg;
        status_next  = status_reg;
        element_next = element_reg;
        slot_next    = slot_reg;
        last_next    = last_reg;

        if (cmd.exec)
        begin
            status_next  = ST_OK;
            element_next = '0;
            slot_next    = '0;
            last_next    = 1'b1;
            case (req.action)
                ACT_INS_FRONT, ACT_INS_REAR, ACT_INS_POS:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (!ins_ok)
                    begin
                        status_next = ST_POS;
                    end
                    else
                    begin
                        // open a gap at the insert point, tail moves back one cell
                        for (int i = 1; i < DEPTH; i++)
                        begin
                            if (IDX_W'(i) > ins_idx)
                            begin
                                cells_next[i] = cells_reg[i-1];
                            end
                            else if (IDX_W'(i) == ins_idx)
                            begin
                                cells_next[i] = req.value;
                            end
                        end
                        if (ins_idx == '0)
                        begin
                            cells_next[0] = req.value;
                        end
                        occ_next  = occ_reg + OCC_W'(1);
                        slot_next = POS_W'(ins_pos);
                    end
                end
                ACT_DEL_FRONT, ACT_DEL_REAR, ACT_DEL_POS:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (!del_ok)
                    begin
                        status_next = ST_POS;
                    end
                    else
                    begin
                        element_next = cells_reg[del_idx];
                        // close the gap, tail moves forward one cell
                        for (int i = 0; i < DEPTH - 1; i++)
                        begin
                            if (IDX_W'(i) >= del_idx)
                            begin
                                cells_next[i] = cells_reg[i+1];
                            end
                        end
                        occ_next  = occ_reg - OCC_W'(1);
                        slot_next = POS_W'(del_pos);
                    end
                end
                ACT_READ:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_idx_next  = '0;
                        element_next = cells_reg[0];
                        slot_next    = POS_W'(1);
                        last_next    = (occ_x == POSX_W'(1));
                    end
                end
                default:
                begin
                    // unused action code: plain ok beat, list untouched
                end
            endcase
        end
        else if (cmd.step)
        begin
            rd_idx_next  = IDX_W'(rd_nxt);
            element_next = cells_reg[IDX_W'(rd_nxt)];
            slot_next    = POS_W'(rd_nxt + POSX_W'(1));
            last_next    = ((rd_nxt + POSX_W'(1)) == occ_x);
        end
        length_next = POS_W'(occ_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            rd_idx_reg <= '0;
            status_reg <= ST_OK;
            slot_reg   <= '0;
            last_reg   <= 1'b1;
        end
        else
        begin
            occ_reg    <= occ_next;
            rd_idx_reg <= rd_idx_next;
            status_reg <= status_next;
            slot_reg   <= slot_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cells_reg   <= cells_next;
        element_reg <= element_next;
        length_reg  <= length_next;
    end

    assign sts.last    = last_reg;
    assign rsp.status  = status_reg;
    assign rsp.element = element_reg;
    assign rsp.slot    = slot_reg;
    assign rsp.length  = length_reg;
    assign rsp.last    = last_reg;

    `POL_ASSERT_ALWAYS(a_occ_bound, POSX_W'(occ_reg) <= DEPTH_X)
    `POL_ASSERT_NEXT(a_step_slot, cmd.step, slot_reg == $past(slot_reg) + POS_W'(1))
    `POL_ASSERT_IMPL(a_err_single, status_reg != ST_OK, last_reg && (slot_reg == '0))

endmodule

`default_nettype wire

// ----- src/positional_ordered_list.sv -----
// ----------------------------------------------------------------------------
// positional_ordered_list
// timing: the result beat is registered, valid the cycle after the request beat
// throughput: one request per cycle for inserts and deletes if rsp_ready is high;
// the cell array shifts at once; a readout gives one beat per element (length beats)
// reset: list empty, no result pending; cell contents are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module positional_ordered_list
    import pol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    pol_cmd_t cmd;
    pol_sts_t sts;

    pol_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    pol_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
